### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker module efc_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also runs during reset
`define ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

### rtl/core/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg
// types and constants of the elevator floor controller
// ----------------------------------------------------------------------------
package efc_pkg;

    localparam int FLOOR_W = 4;
    localparam int MASK_W  = 16;

    // request commands
    localparam logic [1:0] CMD_FLOOR     = 2'd0;
    localparam logic [1:0] CMD_TICK      = 2'd1;
    localparam logic [1:0] CMD_EMERG_ON  = 2'd2;
    localparam logic [1:0] CMD_EMERG_OFF = 2'd3;

    // travel direction codes
    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_IDLE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [FLOOR_W-1:0] target_floor;
    } t_efc_in;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor_now;
        logic [1:0]         heading;
        logic               door_served;
        logic               halted;
        logic [MASK_W-1:0]  pending_mask;
    } t_efc_out;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic [1:0]         travel_dir;
        logic               emergency_on;
        logic [MASK_W-1:0]  request_bits;
    } t_efc_state;

    localparam t_efc_state STATE_RESET = '{
        car_floor:    '0,
        travel_dir:   DIR_IDLE,
        emergency_on: 1'b0,
        request_bits: '0
    };

endpackage

### rtl/core/elevator_floor_controller.sv
// ----------------------------------------------------------------------------
// elevator_floor_controller
// car position, direction, emergency and pending-floor tracking
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one request:
//   a floor call, a movement tick, or emergency enter / leave.
//   output channel (o_out_valid / i_out_ready / o_out_data) returns one
//   status word per request: floor, heading, door served, halted, pending.
//   a request is held in the input register, then its status in the
//   result register.
//   throughput: one request per cycle unless the result stalls; the state
//   update is a single pass of logic between the input and result registers.
//   reset: car at the ground floor, idle, no emergency, no pending calls;
//   both pipeline registers empty.
//   stall: while the result waits, one more request is held in the input
//   register; ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module elevator_floor_controller
    import efc_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_efc_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_efc_out o_out_data
);

    logic       r_in_valid;
    t_efc_in    r_in_data;
    logic       r_out_valid;
    t_efc_out   r_out_data;
    t_efc_state r_state;
    t_efc_state n_state;
    t_efc_out   n_out;
    logic       out_free;
    logic       in_fire;
    logic       advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign advance    = r_in_valid && out_free;

    efc_step #(
        .NUM_FLOORS(NUM_FLOORS)
    ) u_step (
        .i_state  (r_state),
        .i_req    (r_in_data),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/core/efc_step.sv
// ----------------------------------------------------------------------------
// efc_step
// next-state and result logic for one request
// ----------------------------------------------------------------------------
module efc_step
    import efc_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  t_efc_state i_state,
    input  t_efc_in    i_req,
    output t_efc_state o_state,
    output t_efc_out   o_result
);

    localparam int                 TopFloorInt = (NUM_FLOORS > 16) ? 15 : NUM_FLOORS - 1;
    localparam logic [FLOOR_W-1:0] TopFloor    = FLOOR_W'(TopFloorInt);

    logic [FLOOR_W-1:0] mv_floor;
    logic [1:0]         mv_dir;
    logic [MASK_W-1:0]  mv_bit;
    logic [MASK_W-1:0]  req_clr;
    logic [MASK_W-1:0]  above_mask;
    logic [MASK_W-1:0]  below_mask;
    logic               hit;
    logic               served;

    // car movement for a tick
    always_comb begin
        mv_floor = i_state.car_floor;
        mv_dir   = i_state.travel_dir;
        if (i_state.travel_dir == DIR_UP) begin
            if (i_state.car_floor < TopFloor) begin
                mv_floor = i_state.car_floor + FLOOR_W'(1);
            end else begin
                mv_dir   = DIR_DOWN;
                mv_floor = i_state.car_floor - FLOOR_W'(1);
            end
        end else if (i_state.travel_dir == DIR_DOWN) begin
            if (i_state.car_floor != '0) begin
                mv_floor = i_state.car_floor - FLOOR_W'(1);
            end else begin
                mv_dir = DIR_IDLE;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            mv_bit[i]     = (FLOOR_W'(i) == mv_floor);
            above_mask[i] = (FLOOR_W'(i) > mv_floor);
            below_mask[i] = (FLOOR_W'(i) < mv_floor);
        end
    end

    assign hit     = i_state.request_bits[mv_floor];
    assign req_clr = i_state.request_bits & ~mv_bit;

    always_comb begin
        o_state = i_state;
        served  = 1'b0;
        unique case (i_req.command)
            CMD_FLOOR: begin
                if (i_req.target_floor <= TopFloor) begin
                    o_state.request_bits[i_req.target_floor] = 1'b1;
                    if (i_state.travel_dir == DIR_IDLE) begin
                        if (i_req.target_floor > i_state.car_floor) begin
                            o_state.travel_dir = DIR_UP;
                        end else if (i_req.target_floor < i_state.car_floor) begin
                            o_state.travel_dir = DIR_DOWN;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (!i_state.emergency_on) begin
                    o_state.car_floor  = mv_floor;
                    o_state.travel_dir = mv_dir;
                    if (hit) begin
                        served               = 1'b1;
                        o_state.request_bits = req_clr;
                        // reverse when nothing is left ahead
                        if (mv_dir == DIR_UP && (req_clr & above_mask) == '0) begin
                            o_state.travel_dir = DIR_DOWN;
                        end else if (mv_dir == DIR_DOWN && (req_clr & below_mask) == '0) begin
                            o_state.travel_dir = DIR_UP;
                        end
                    end
                end
            end
            CMD_EMERG_ON: begin
                o_state.emergency_on = 1'b1;
            end
            CMD_EMERG_OFF: begin
                o_state.emergency_on = 1'b0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_result.floor_now    = o_state.car_floor;
    assign o_result.heading      = o_state.travel_dir;
    assign o_result.door_served  = served;
    assign o_result.halted       = o_state.emergency_on;
    assign o_result.pending_mask = o_state.request_bits;

endmodule

### rtl/core/efc_checker.sv
// ----------------------------------------------------------------------------
// efc_checker
// port-level checks for the elevator floor controller
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efc_checker
    import efc_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_efc_out o_out_data
);

    logic out_stall;
    logic out_door;
    logic door_bit;

    assign out_stall = o_out_valid && !i_out_ready;
    assign out_door  = o_out_valid && o_out_data.door_served;
    assign door_bit  = o_out_data.pending_mask[o_out_data.floor_now];

    // a stalled result keeps its valid and its status word
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> o_out_valid && $stable(o_out_data))

    `ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // a served floor is no longer pending
    `ASSERT_CLK(a_served_clear, i_clk, i_rst_n, out_door |-> !door_bit)

    // no door cycle while the car is halted
    `ASSERT_CLK(a_halt_no_door, i_clk, i_rst_n, o_out_valid && o_out_data.halted |-> !out_door)

    // an empty result register never blocks the input side
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

endmodule

bind elevator_floor_controller efc_checker u_efc_checker (.*);

### tb/efc_status_checker.sv
// ----------------------------------------------------------------------------
// efc_status_checker
// watches both channels of the elevator floor controller, tracks the car on
// its own and compares every returned status word with the predicted one
// ----------------------------------------------------------------------------
module efc_status_checker
    import efc_pkg::*;
#(
    parameter int NUM_FLOORS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_ready,
    input  t_efc_in  i_in_data,
    input  logic     i_out_valid,
    input  logic     i_out_ready,
    input  t_efc_out i_out_data,
    output int       o_fail_count,
    output int       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // floor and mask widths cap the building at sixteen floors
    localparam logic [FLOOR_W-1:0] TOP_FLOOR =
        (NUM_FLOORS > 16) ? FLOOR_W'(15) : FLOOR_W'(NUM_FLOORS - 1);

    t_efc_state car_model;
    t_efc_out   expected_status[$];
    int         fail_total;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        fail_total    = 0;
        car_model     = STATE_RESET;
    end

    function automatic t_efc_state advance_car(input t_efc_state st, input t_efc_in req,
                                               output logic served);
        logic [MASK_W-1:0] above_mask;
        logic [MASK_W-1:0] below_mask;
        served = 1'b0;
        case (req.command)
            CMD_FLOOR: begin
                if (req.target_floor <= TOP_FLOOR) begin
                    st.request_bits[req.target_floor] = 1'b1;
                    if (st.travel_dir == DIR_IDLE) begin
                        if (req.target_floor > st.car_floor)
                            st.travel_dir = DIR_UP;
                        else if (req.target_floor < st.car_floor)
                            st.travel_dir = DIR_DOWN;
                    end
                end
            end
            CMD_TICK: begin
                if (!st.emergency_on) begin
                    if (st.travel_dir == DIR_UP) begin
                        if (st.car_floor < TOP_FLOOR) begin
                            st.car_floor = st.car_floor + 1'b1;
                        end else begin
                            // bounce off the top floor
                            st.travel_dir = DIR_DOWN;
                            st.car_floor  = st.car_floor - 1'b1;
                        end
                    end else if (st.travel_dir == DIR_DOWN) begin
                        if (st.car_floor != '0)
                            st.car_floor = st.car_floor - 1'b1;
                        else
                            st.travel_dir = DIR_IDLE;
                    end
                    if (st.request_bits[st.car_floor]) begin
                        served = 1'b1;
                        st.request_bits[st.car_floor] = 1'b0;
                        above_mask = ~((MASK_W'(2) << st.car_floor) - MASK_W'(1));
                        below_mask = (MASK_W'(1) << st.car_floor) - MASK_W'(1);
                        // turn around when nothing is left ahead
                        if (st.travel_dir == DIR_UP && (st.request_bits & above_mask) == '0)
                            st.travel_dir = DIR_DOWN;
                        else if (st.travel_dir == DIR_DOWN &&
                                 (st.request_bits & below_mask) == '0)
                            st.travel_dir = DIR_UP;
                    end
                end
            end
            CMD_EMERG_ON: st.emergency_on = 1'b1;
            default:      st.emergency_on = 1'b0;
        endcase
        return st;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
                     act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_efc_out exp_status;
        logic     served;
        if (!i_rst_n) begin
            car_model = STATE_RESET;
            expected_status.delete();
        end else begin
            // a status accepted now always belongs to an earlier request
            if (i_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected status, expected none, got %0h", $time,
                             i_out_data);
                    fail_total++;
                end else begin
                    exp_status = expected_status.pop_front();
                    check_field("floor_now", exp_status.floor_now, i_out_data.floor_now);
                    check_field("heading", exp_status.heading, i_out_data.heading);
                    check_field("door_served", exp_status.door_served,
                                i_out_data.door_served);
                    check_field("halted", exp_status.halted, i_out_data.halted);
                    check_field("pending_mask", exp_status.pending_mask,
                                i_out_data.pending_mask);
                end
            end
            if (i_in_valid && i_in_ready) begin
                car_model = advance_car(car_model, i_in_data, served);
                exp_status.floor_now    = car_model.car_floor;
                exp_status.heading      = car_model.travel_dir;
                exp_status.door_served  = served;
                exp_status.halted       = car_model.emergency_on;
                exp_status.pending_mask = car_model.request_bits;
                expected_status.push_back(exp_status);
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_status.size();
    end

endmodule

### tb/elevator_floor_controller_tb.sv
// ----------------------------------------------------------------------------
// elevator_floor_controller_tb
// drives floor calls, movement ticks and emergency requests into the
// controller under random flow control and takes the verdict from the checker
// ----------------------------------------------------------------------------
module elevator_floor_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import efc_pkg::*;

    localparam int FLOORS = 16;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_efc_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_efc_out out_data;
    int       fail_count;
    int       outstanding;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    always #5 clk = ~clk;

    elevator_floor_controller #(
        .NUM_FLOORS(FLOORS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    efc_status_checker #(
        .NUM_FLOORS(FLOORS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(input logic [1:0] cmd, input logic [FLOOR_W-1:0] floor);
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, target_floor: floor};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // mostly calls and ticks so the car keeps travelling
    task automatic send_random_request();
        int roll;
        roll = $urandom_range(99);
        if (roll < 32)
            send_request(CMD_FLOOR, FLOOR_W'($urandom));
        else if (roll < 91)
            send_request(CMD_TICK, FLOOR_W'($urandom));
        else if (roll < 94)
            send_request(CMD_EMERG_ON, FLOOR_W'($urandom));
        else
            send_request(CMD_EMERG_OFF, FLOOR_W'($urandom));
    endtask

    task automatic drain_status();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // call at the car's own floor while idle, then served in place
        send_request(CMD_FLOOR, 4'd0);
        send_request(CMD_TICK, 4'd0);
        // idle tick with nothing pending
        send_request(CMD_TICK, 4'd15);
        send_request(CMD_FLOOR, 4'd2);
        send_request(CMD_EMERG_ON, 4'd0);
        send_request(CMD_EMERG_ON, 4'd9);
        // tick blocked, call still taken during emergency
        send_request(CMD_TICK, 4'd0);
        send_request(CMD_FLOOR, 4'd5);
        send_request(CMD_EMERG_OFF, 4'd0);
        send_request(CMD_EMERG_OFF, 4'd0);
        repeat (5) send_request(CMD_TICK, 4'd0);
        // ride down to the ground floor, car goes idle
        repeat (6) send_request(CMD_TICK, 4'd0);
        send_request(CMD_FLOOR, 4'd15);
        send_request(CMD_FLOOR, 4'd10);
        drain_status();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 30 : 0;
            repeat (384) send_random_request();
            // after the first phase, hold off until every status is back
            if (phase == 0)
                drain_status();
        end

        drain_status();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/efc_pkg.sv
rtl/core/efc_step.sv
rtl/core/elevator_floor_controller.sv
rtl/core/efc_checker.sv
tb/efc_status_checker.sv
tb/elevator_floor_controller_tb.sv
